FILE: hdl/spm_pkg.sv
package spm_pkg;
  localparam int PageBytesDef   = 4096;
  localparam int MaxSlotsDef    = 256;
  localparam int HeaderBytesDef = 8;
  localparam int SlotBytesDef   = 4;

  localparam logic [2:0] KIND_INIT   = 3'd0;
  localparam logic [2:0] KIND_INSERT = 3'd1;
  localparam logic [2:0] KIND_DELETE = 3'd2;
  localparam logic [2:0] KIND_RESIZE = 3'd3;
  localparam logic [2:0] KIND_WRITE  = 3'd4;
  localparam logic [2:0] KIND_READ   = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SPACE = 2'd1;
  localparam logic [1:0] ST_SLOT  = 2'd2;
  localparam logic [1:0] ST_POS   = 2'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  slot_index;
    logic [12:0] tuple_size;
    logic [11:0] byte_position;
    logic [7:0]  data_byte;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  slot_result;
    logic [12:0] tuple_offset;
    logic [12:0] free_bytes;
    logic [7:0]  read_byte;
  } rsp_t;
endpackage

FILE: hdl/spm_if.sv
interface spm_req_if;
  logic valid;
  logic ready;
  spm_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface spm_rsp_if;
  logic valid;
  logic ready;
  spm_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: hdl/slotted_page_manager.sv
// Slotted page manager.
// Request channel req (spm_req_if sink) takes one beat per operation: kind,
// slot_index, tuple_size, byte_position, data_byte. Response channel rsp
// (spm_rsp_if source) returns exactly one beat per request: status,
// slot_result, tuple_offset, free_bytes, read_byte.
// One operation is in flight at a time; req_ready is high only when idle.
// Steps from request beat to response: init, unused kinds and failed checks
// go through slot read and check; a successful insert adds a final slot write;
// write and read add the byte access (slot read, check, byte access). Delete
// and resize also move the L data bytes between the boundary and the tuple,
// each read and written back, then pass over the S slot entries (S is
// slot_count), each read and, if it lies below the tuple, re-pointed.
// After the response register is loaded the block returns to idle and takes
// the next request from there.
// The response register holds its beat until taken. While it is full, a
// finished operation waits with its result and the request side stalls.
// Reset clears slot valid bits, slot count and output valid, and sets the
// boundary to the page size. No clearing pass is needed; the page and slot
// memories are undefined until written.
module slotted_page_manager #(
  parameter int PAGE_BYTES   = spm_pkg::PageBytesDef,
  parameter int MAX_SLOTS    = spm_pkg::MaxSlotsDef,
  parameter int HEADER_BYTES = spm_pkg::HeaderBytesDef,
  parameter int SLOT_BYTES   = spm_pkg::SlotBytesDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  spm_req_if.sink   req,
  spm_rsp_if.source rsp
);
  import spm_pkg::*;

  localparam int PA = $clog2(PAGE_BYTES);
  localparam int SA = $clog2(MAX_SLOTS);
  localparam int OW = PA + 1;
  localparam int W  = 18;

  localparam logic [3:0] S_IDLE = 4'd0, S_SRD = 4'd1, S_CHK = 4'd2,
                         S_BYTE = 4'd3, S_BWAIT = 4'd4, S_MRD = 4'd5,
                         S_MWR = 4'd6, S_SW_RD = 4'd7, S_SW_CHK = 4'd8,
                         S_FIN = 4'd9, S_RSP = 4'd10;

  logic [3:0] st_q, st_d;
  req_t r_q;
  logic [MAX_SLOTS-1:0] valid_q;
  logic [SA:0] cnt_q;
  logic [W-1:0] bnd_q;
  logic [W-1:0] off_q, delta_q;
  logic up_q;
  logic [W-1:0] mv_q, mvend_q;
  logic [SA:0] sw_q;
  rsp_t res_q, out_q;
  logic out_v_q;

  logic pwe;
  logic [PA-1:0] pwa, pra;
  logic [7:0] pwd, prd;
  logic swe;
  logic [SA-1:0] swa, sra;
  logic [2*OW-1:0] swd, srd;

  spm_page_ram #(.Depth(PAGE_BYTES)) u_page (
    .clk_i, .we_i(pwe), .waddr_i(pwa), .wdata_i(pwd), .raddr_i(pra), .rdata_o(prd));
  spm_slot_ram #(.Depth(MAX_SLOTS), .Ow(OW)) u_slot (
    .clk_i, .we_i(swe), .waddr_i(swa), .wdata_i(swd), .raddr_i(sra), .rdata_o(srd));

  logic [W-1:0] freev, srd_off, srd_len, sz, pos, addr, mv_dst;
  logic [SA-1:0] idx;
  logic sok, ins_ok, grow, rsz_ok, pos_ok, mv_need, sw_last, load_out;

  assign freev = (bnd_q >= W'(HEADER_BYTES) + W'(SLOT_BYTES) * W'(cnt_q)) ?
                 bnd_q - W'(HEADER_BYTES) - W'(SLOT_BYTES) * W'(cnt_q) : '0;
  assign srd_off = W'(srd[2*OW-1:OW]);
  assign srd_len = W'(srd[OW-1:0]);
  assign sz = W'(r_q.tuple_size);
  assign pos = W'(r_q.byte_position);
  assign addr = off_q + pos;
  assign mv_dst = up_q ? mv_q + delta_q : mv_q - delta_q;
  assign idx = SA'(r_q.slot_index);
  assign sok = (W'(r_q.slot_index) < W'(cnt_q)) && valid_q[idx];
  assign ins_ok = (W'(cnt_q) < W'(MAX_SLOTS)) && (sz + W'(SLOT_BYTES) <= freev);
  assign grow = sz > srd_len;
  assign rsz_ok = !grow || (sz - srd_len <= freev);
  assign pos_ok = pos < srd_len;
  assign mv_need = srd_off != bnd_q;
  assign sw_last = (sw_q + (SA+1)'(1)) == cnt_q;
  assign load_out = (st_q == S_RSP) && (!out_v_q || rsp.ready);

  assign req.ready = (st_q == S_IDLE);
  assign rsp.valid = out_v_q;
  assign rsp.payload = out_q;

  always_comb begin
    pwe = 1'b0; pwa = addr[PA-1:0]; pwd = r_q.data_byte; pra = addr[PA-1:0];
    swe = 1'b0; swa = idx; swd = '0;
    sra = idx;
    st_d = st_q;
    case (st_q)
      S_IDLE: if (req.valid && req.ready) st_d = S_SRD;
      S_SRD:  st_d = S_CHK;
      S_CHK: begin
        st_d = S_RSP;
        case (r_q.kind)
          KIND_INSERT: if (ins_ok) st_d = S_FIN;
          KIND_DELETE: if (sok) st_d = mv_need ? S_MRD : S_SW_RD;
          KIND_RESIZE: if (sok && rsz_ok) st_d = mv_need ? S_MRD : S_SW_RD;
          KIND_WRITE, KIND_READ: if (sok && pos_ok) st_d = S_BYTE;
          default: ;
        endcase
      end
      S_BYTE: begin
        pwe = (r_q.kind == KIND_WRITE);
        st_d = S_BWAIT;
      end
      S_BWAIT: st_d = S_RSP;
      S_MRD: begin
        pra = mv_q[PA-1:0];
        st_d = S_MWR;
      end
      S_MWR: begin
        pwe = 1'b1; pwa = mv_dst[PA-1:0]; pwd = prd;
        st_d = (mv_q == mvend_q) ? S_SW_RD : S_MRD;
      end
      S_SW_RD: begin
        sra = sw_q[SA-1:0];
        st_d = S_SW_CHK;
      end
      S_SW_CHK: begin
        swa = sw_q[SA-1:0];
        swd = {OW'(up_q ? srd_off + delta_q : srd_off - delta_q), srd[OW-1:0]};
        swe = valid_q[sw_q[SA-1:0]] && (srd_off < off_q);
        st_d = sw_last ? S_FIN : S_SW_RD;
      end
      S_FIN: begin
        if (r_q.kind == KIND_INSERT) begin
          swe = 1'b1;
          swa = cnt_q[SA-1:0];
          swd = {OW'(off_q), OW'(sz)};
        end else if (r_q.kind == KIND_RESIZE) begin
          swe = 1'b1;
          swd = {OW'(res_q.tuple_offset), OW'(sz)};
        end
        st_d = S_RSP;
      end
      S_RSP: if (!out_v_q || rsp.ready) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      r_q <= '0;
      valid_q <= '0;
      cnt_q <= '0;
      bnd_q <= W'(PAGE_BYTES);
      off_q <= '0;
      delta_q <= '0;
      up_q <= 1'b0;
      mv_q <= '0;
      mvend_q <= '0;
      sw_q <= '0;
      res_q <= '0;
      out_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (load_out) begin
        out_q <= '{res_q.status, res_q.slot_result, res_q.tuple_offset, 13'(freev),
                   res_q.read_byte};
        out_v_q <= 1'b1;
      end else if (rsp.ready) out_v_q <= 1'b0;
      case (st_q)
        S_IDLE: if (req.valid && req.ready) begin
          r_q <= req.payload;
          res_q <= '{ST_OK, req.payload.slot_index, 13'd0, 13'd0, 8'd0};
        end
        S_CHK: begin
          off_q <= (r_q.kind == KIND_INSERT) ? bnd_q - sz : srd_off;
          sw_q <= '0;
          case (r_q.kind)
            KIND_INIT: begin
              cnt_q <= '0; bnd_q <= W'(PAGE_BYTES); valid_q <= '0;
              res_q.slot_result <= 8'd0;
            end
            KIND_INSERT: begin
              res_q.slot_result <= ins_ok ? 8'(cnt_q) : 8'd0;
              if (ins_ok) res_q.tuple_offset <= 13'(bnd_q - sz);
              else res_q.status <= ST_SPACE;
            end
            KIND_DELETE, KIND_RESIZE, KIND_WRITE, KIND_READ: begin
              if (!sok) res_q.status <= ST_SLOT;
              else if (r_q.kind == KIND_DELETE) begin
                up_q <= 1'b1; delta_q <= srd_len;
                res_q.tuple_offset <= 13'(srd_off);
                valid_q[idx] <= 1'b0;
                mv_q <= srd_off - W'(1); mvend_q <= bnd_q;
              end else if (r_q.kind == KIND_RESIZE) begin
                if (!rsz_ok) res_q.status <= ST_SPACE;
                else begin
                  up_q <= !grow;
                  delta_q <= grow ? sz - srd_len : srd_len - sz;
                  res_q.tuple_offset <= 13'(grow ? srd_off - (sz - srd_len)
                                                 : srd_off + (srd_len - sz));
                  mv_q <= grow ? bnd_q : srd_off - W'(1);
                  mvend_q <= grow ? srd_off - W'(1) : bnd_q;
                end
              end else if (!pos_ok) res_q.status <= ST_POS;
              else res_q.tuple_offset <= 13'(srd_off);
            end
            default: ;
          endcase
        end
        S_BWAIT: if (r_q.kind == KIND_READ) res_q.read_byte <= prd;
        S_MWR: begin
          // Moving up copies from the top down; moving down copies bottom up.
          if (mv_q != mvend_q) mv_q <= up_q ? mv_q - W'(1) : mv_q + W'(1);
        end
        S_SW_CHK: sw_q <= sw_q + (SA+1)'(1);
        S_FIN: begin
          if (r_q.kind == KIND_INSERT) begin
            valid_q[cnt_q[SA-1:0]] <= 1'b1;
            cnt_q <= cnt_q + (SA+1)'(1);
            bnd_q <= off_q;
          end else bnd_q <= up_q ? bnd_q + delta_q : bnd_q - delta_q;
        end
        default: ;
      endcase
    end
  end
endmodule

FILE: hdl/spm_page_ram.sv
module spm_page_ram #(
  parameter int Depth = spm_pkg::PageBytesDef,
  parameter int Aw    = $clog2(Depth)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [Aw-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [Aw-1:0] raddr_i,
  output logic [7:0]    rdata_o
);
  logic [7:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

FILE: hdl/spm_slot_ram.sv
module spm_slot_ram #(
  parameter int Depth = spm_pkg::MaxSlotsDef,
  parameter int Aw    = $clog2(Depth),
  parameter int Ow    = 13
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [Aw-1:0]   waddr_i,
  input  logic [2*Ow-1:0] wdata_i,
  input  logic [Aw-1:0]   raddr_i,
  output logic [2*Ow-1:0] rdata_o
);
  logic [2*Ow-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

FILE: hdl/spm_checker.sv
module spm_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic [1:0] status,
  input logic [12:0] free_bytes
);
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid) else $error("rsp dropped");
  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> $stable(status) && $stable(free_bytes))
    else $error("rsp changed while stalled");
  a_one_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready |=> !req_ready) else $error("second request taken");
  a_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> free_bytes <= 13'd4096) else $error("free out of range");
endmodule

bind slotted_page_manager spm_checker u_chk (
  .clk_i, .rst_ni, .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .status(rsp.payload.status),
  .free_bytes(rsp.payload.free_bytes));

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import spm_pkg::*;

  localparam int PageSz   = PageBytesDef;
  localparam int SlotsMax = MaxSlotsDef;
  localparam int HdrSz    = HeaderBytesDef;
  localparam int EntrySz  = SlotBytesDef;
  localparam int StallLimit = 40000;
  localparam logic [2:0] KIND_UNUSED6 = 3'd6;
  localparam logic [2:0] KIND_UNUSED7 = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  spm_req_if req ();
  spm_rsp_if rsp ();

  slotted_page_manager i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req),
    .rsp    (rsp)
  );

  always #5 clk_i = ~clk_i;

  // page image kept alongside the block
  logic [7:0]  page_img [PageSz];
  bit          page_known [PageSz];
  logic [12:0] dir_off [SlotsMax];
  logic [12:0] dir_len [SlotsMax];
  bit          dir_live [SlotsMax];
  int unsigned dir_count;
  int unsigned boundary;

  rsp_t expected_rsp_q [$];
  int   err_cnt = 0;
  int   burst_left = 0;
  int   hold_cycles = 0;
  int   quiet_cycles = 0;

  function automatic int unsigned page_free();
    int f;
    f = int'(boundary) - HdrSz - EntrySz * int'(dir_count);
    return (f < 0) ? 0 : f;
  endfunction

  function automatic void move_below(int unsigned top, int delta);
    logic [7:0] tmp_b [PageSz];
    bit tmp_k [PageSz];
    int unsigned n;
    n = top - boundary;
    for (int i = 0; i < n; i++) begin
      tmp_b[i] = page_img[boundary + i];
      tmp_k[i] = page_known[boundary + i];
    end
    for (int i = 0; i < n; i++) begin
      page_img[int'(boundary) + delta + i] = tmp_b[i];
      page_known[int'(boundary) + delta + i] = tmp_k[i];
    end
    for (int i = 0; i < dir_count; i++)
      if (dir_live[i] && dir_off[i] < top) dir_off[i] = 13'(int'(dir_off[i]) + delta);
    boundary = int'(boundary) + delta;
  endfunction

  function automatic rsp_t apply_op(req_t r);
    rsp_t o;
    int unsigned s, off, len;
    int delta;
    o = '0;
    s = 32'(r.slot_index);
    o.slot_result = r.slot_index;
    case (r.kind)
      KIND_INIT: begin
        dir_count = 0;
        boundary = PageSz;
        for (int i = 0; i < SlotsMax; i++) dir_live[i] = 1'b0;
        o.slot_result = '0;
      end
      KIND_INSERT: begin
        o.slot_result = '0;
        if (dir_count >= SlotsMax || r.tuple_size + EntrySz > page_free()) begin
          o.status = ST_SPACE;
        end else begin
          boundary -= r.tuple_size;
          dir_off[dir_count] = 13'(boundary);
          dir_len[dir_count] = r.tuple_size;
          dir_live[dir_count] = 1'b1;
          o.slot_result = 8'(dir_count);
          o.tuple_offset = 13'(boundary);
          dir_count++;
        end
      end
      KIND_DELETE, KIND_RESIZE, KIND_WRITE, KIND_READ: begin
        if (!(s < dir_count && dir_live[s])) begin
          o.status = ST_SLOT;
        end else begin
          off = 32'(dir_off[s]);
          len = 32'(dir_len[s]);
          if (r.kind == KIND_DELETE) begin
            dir_live[s] = 1'b0;
            move_below(off, int'(len));
            o.tuple_offset = 13'(off);
          end else if (r.kind == KIND_RESIZE) begin
            delta = int'(len) - int'(r.tuple_size);
            if (delta < 0 && -delta > int'(page_free())) begin
              o.status = ST_SPACE;
            end else begin
              move_below(off, delta);
              dir_off[s] = 13'(int'(off) + delta);
              dir_len[s] = r.tuple_size;
              o.tuple_offset = dir_off[s];
            end
          end else if (r.byte_position >= len) begin
            o.status = ST_POS;
          end else begin
            o.tuple_offset = 13'(off);
            if (r.kind == KIND_WRITE) begin
              page_img[off + r.byte_position] = r.data_byte;
              page_known[off + r.byte_position] = 1'b1;
            end else begin
              o.read_byte = page_img[off + r.byte_position];
            end
          end
        end
      end
      default: ;
    endcase
    o.free_bytes = 13'(page_free());
    return o;
  endfunction

  task automatic send_op(input req_t r);
    if (burst_left == 0) begin
      @(negedge clk_i);
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    @(negedge clk_i);
    req.valid <= 1'b1;
    req.payload <= r;
    do @(posedge clk_i); while (!req.ready);
    expected_rsp_q.push_back(apply_op(r));
  endtask

  task automatic do_op(input logic [2:0] k, input int unsigned s, input int unsigned sz,
                       input int unsigned pos, input int unsigned d);
    req_t r;
    r.kind = k;
    r.slot_index = 8'(s);
    r.tuple_size = 13'(sz);
    r.byte_position = 12'(pos);
    r.data_byte = 8'(d);
    send_op(r);
  endtask

  // read a byte known to hold data, else write one; for a dead or empty slot, read or write at random
  task automatic access_slot(input int unsigned s);
    int unsigned p;
    bool_search: begin
      if (s < dir_count && dir_live[s] && dir_len[s] != 0) begin
        for (int t = 0; t < 8; t++) begin
          p = $urandom_range(0, dir_len[s] - 1);
          if (page_known[dir_off[s] + p]) begin
            do_op(KIND_READ, s, $urandom_range(0, 8191), p, $urandom_range(0, 255));
            disable bool_search;
          end
        end
        do_op(KIND_WRITE, s, $urandom_range(0, 8191), p, $urandom_range(0, 255));
      end else begin
        do_op(($urandom_range(0, 1) != 0) ? KIND_READ : KIND_WRITE, s,
              $urandom_range(0, 8191), $urandom_range(0, 4095), $urandom_range(0, 255));
      end
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    req.valid <= 1'b0;
    wait (expected_rsp_q.size() == 0);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic test_directed();
    do_op(KIND_INIT, 0, 0, 0, 0);
    do_op(KIND_READ, 0, 0, 0, 0);
    do_op(KIND_INSERT, 0, 4084, 0, 0);
    do_op(KIND_INSERT, 0, 0, 0, 0);
    do_op(KIND_DELETE, 0, 0, 0, 0);
    do_op(KIND_INIT, 0, 0, 0, 0);
    do_op(KIND_INSERT, 0, 0, 0, 0);
    do_op(KIND_INSERT, 0, 16, 0, 0);
    do_op(KIND_INSERT, 0, 4096, 0, 0);
    do_op(KIND_INSERT, 0, 8191, 0, 0);
    do_op(KIND_WRITE, 1, 0, 0, 8'hFF);
    do_op(KIND_WRITE, 1, 0, 15, 8'h00);
    do_op(KIND_WRITE, 1, 0, 16, 8'hA5);
    do_op(KIND_READ, 1, 0, 0, 0);
    do_op(KIND_READ, 1, 0, 4095, 0);
    do_op(KIND_WRITE, 0, 0, 0, 8'h5A);
    do_op(KIND_INSERT, 0, 32, 0, 0);
    do_op(KIND_RESIZE, 1, 24, 0, 0);
    do_op(KIND_READ, 1, 0, 8, 0);
    do_op(KIND_RESIZE, 1, 4, 0, 0);
    do_op(KIND_READ, 1, 0, 3, 0);
    do_op(KIND_RESIZE, 2, 8191, 0, 0);
    do_op(KIND_DELETE, 1, 0, 0, 0);
    do_op(KIND_DELETE, 1, 0, 0, 0);
    do_op(KIND_DELETE, 255, 0, 0, 0);
    do_op(KIND_UNUSED6, 3, 100, 7, 1);
    do_op(KIND_UNUSED7, 255, 8191, 4095, 255);
    drain();
  endtask

  task automatic test_backpressure();
    hold_cycles = 300;
    for (int i = 0; i < 4; i++) do_op(KIND_INSERT, 0, $urandom_range(0, 16), 0, 0);
    drain();
  endtask

  task automatic test_random();
    int unsigned sel, s, sz;
    for (int n = 0; n < 100; n++) begin
      sel = $urandom_range(0, 99);
      s = (dir_count != 0 && $urandom_range(0, 9) != 0) ?
          $urandom_range(0, dir_count - 1) : $urandom_range(0, 255);
      sz = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 48);
      if (sel < 2) do_op(KIND_INIT, s, sz, $urandom_range(0, 4095), $urandom_range(0, 255));
      else if (sel < 32) do_op(KIND_INSERT, s, sz, $urandom_range(0, 4095),
                               $urandom_range(0, 255));
      else if (sel < 42) do_op(KIND_DELETE, s, sz, 0, 0);
      else if (sel < 52) do_op(KIND_RESIZE, s, sz, 0, 0);
      else if (sel < 97) access_slot(s);
      else do_op(($urandom_range(0, 1) != 0) ? KIND_UNUSED6 : KIND_UNUSED7, s, sz,
                 $urandom_range(0, 4095), $urandom_range(0, 255));
    end
    @(negedge clk_i);
    req.valid <= 1'b0;
    drain();
  endtask

  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      rsp.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      case (($time / 640) % 3)
        0: rsp.ready <= 1'b1;
        1: rsp.ready <= ($urandom_range(0, 3) != 0);
        default: rsp.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    rsp_t exp_r;
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (expected_rsp_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected beat %p", rsp.payload);
      end else begin
        exp_r = expected_rsp_q.pop_front();
        if (rsp.payload.status !== exp_r.status ||
            rsp.payload.slot_result !== exp_r.slot_result ||
            rsp.payload.tuple_offset !== exp_r.tuple_offset ||
            rsp.payload.free_bytes !== exp_r.free_bytes ||
            rsp.payload.read_byte !== exp_r.read_byte) begin
          err_cnt++;
          if (err_cnt <= 10) $display("mismatch exp %p got %p", exp_r, rsp.payload);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    req.valid = 1'b0;
    req.payload = '0;
    rsp.ready = 1'b0;
    dir_count = 0;
    boundary = PageSz;
    for (int i = 0; i < PageSz; i++) begin
      page_img[i] = '0;
      page_known[i] = 1'b0;
    end
    for (int i = 0; i < SlotsMax; i++) dir_live[i] = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_backpressure();
    test_random();
    repeat (50) @(posedge clk_i);
    if (err_cnt == 0 && expected_rsp_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
